// ===== design/rdd_pkg.sv =====
// Shared types, constants and the quadrature transition decoder for the
// rotary dial detent and button block. No dependencies.
package rdd_pkg;

  // Default width of the tick time base
  localparam int unsigned TIME_BITS_DEFAULT = 32;

  // Configuration port geometry
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PULSES_PER_DETENT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TICKS  = 2'd2;

  // Register widths and reset values
  localparam int unsigned PPD_W       = 5;
  localparam int unsigned DEBOUNCE_W  = 10;
  localparam int unsigned LONG_W      = 16;
  localparam logic [PPD_W-1:0]      PPD_RESET      = 5'd4;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd30;
  localparam logic [LONG_W-1:0]     LONG_RESET     = 16'd500;

  // Detent residual width
  localparam int unsigned RESIDUAL_W = 6;

  // Output field widths
  localparam int unsigned HELD_W = 32;

  // Detent step codes
  localparam logic signed [1:0] DETENT_NONE = 2'sb00;
  localparam logic signed [1:0] DETENT_UP   = 2'sb01;
  localparam logic signed [1:0] DETENT_DOWN = 2'sb11;

  // Press event codes
  localparam logic [1:0] EVENT_NONE  = 2'd0;
  localparam logic [1:0] EVENT_SHORT = 2'd1;
  localparam logic [1:0] EVENT_LONG  = 2'd2;

  // Button levels (active low)
  localparam logic BUTTON_PRESSED  = 1'b0;
  localparam logic BUTTON_RELEASED = 1'b1;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [PPD_W-1:0]      pulses_per_detent;
    logic [DEBOUNCE_W-1:0] debounce_ticks;
    logic [LONG_W-1:0]     long_press_ticks;
  } rdd_cfg_t;

  // Quadrature transition: {prev A, prev B, A, B} -> raw step.
  // Double steps and no-change codes give no step.
  function automatic logic signed [1:0] transition_step(input logic [3:0] code);
    logic signed [1:0] step;
    step = DETENT_NONE;
    unique case (code)
      4'b0001, 4'b0111, 4'b1110, 4'b1000: step = DETENT_DOWN;
      4'b0010, 4'b1011, 4'b1101, 4'b0100: step = DETENT_UP;
      default:                            step = DETENT_NONE;
    endcase
    return step;
  endfunction

endpackage

// ===== design/rdd_quad.sv =====
// Quadrature step decoder and detent residual tracker.
// Depends on rdd_pkg for the transition table and codes.
module rdd_quad (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic [1:0]                     lines,
  input  logic [rdd_pkg::PPD_W-1:0]      pulses_per_detent,
  output logic signed [1:0]              detent
);
  import rdd_pkg::*;

  logic [1:0]                   prev_lines;
  logic                         primed;
  logic signed [RESIDUAL_W-1:0] residual;
  logic signed [RESIDUAL_W-1:0] residual_next;

  logic signed [1:0]            step;
  logic signed [RESIDUAL_W:0]   sum;
  logic signed [RESIDUAL_W:0]   ppd;

  // Raw step, suppressed until the previous lines are known
  assign step = primed ? transition_step({prev_lines, lines}) : DETENT_NONE;

  // Zero pulses per detent acts as one
  assign ppd = (pulses_per_detent == '0) ? (RESIDUAL_W+1)'(1)
                                         : (RESIDUAL_W+1)'(pulses_per_detent);

  // Residual update, at most one detent per sample
  always_comb begin
    sum = (RESIDUAL_W+1)'(residual) + (RESIDUAL_W+1)'(step);
    if (sum >= ppd) begin
      detent        = DETENT_UP;
      residual_next = RESIDUAL_W'(sum - ppd);
    end else if (sum <= -ppd) begin
      detent        = DETENT_DOWN;
      residual_next = RESIDUAL_W'(sum + ppd);
    end else begin
      detent        = DETENT_NONE;
      residual_next = RESIDUAL_W'(sum);
    end
  end

  // State
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_lines <= '0;
      primed     <= 1'b0;
      residual   <= '0;
    end else if (en) begin
      prev_lines <= lines;
      primed     <= 1'b1;
      residual   <= residual_next;
    end
  end

endmodule

// ===== design/rdd_button.sv =====
// Button debounce, tick time base and press duration measurement.
// Depends on rdd_pkg for codes and the configuration struct.
module rdd_button #(
  parameter int unsigned TIME_BITS = rdd_pkg::TIME_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        level,
  input  rdd_pkg::rdd_cfg_t           cfg,
  output logic [1:0]                  event_code,
  output logic [rdd_pkg::HELD_W-1:0]  held
);
  import rdd_pkg::*;

  localparam int unsigned WIDE_W = (TIME_BITS > HELD_W) ? TIME_BITS : HELD_W;

  logic [TIME_BITS-1:0] tick_count;
  logic [TIME_BITS-1:0] last_change_time;
  logic [TIME_BITS-1:0] press_time;
  logic                 stable_button;

  logic [TIME_BITS-1:0] since_change;
  logic [TIME_BITS-1:0] held_time;
  logic [WIDE_W-1:0]    held_wide;
  logic                 accept_level;

  // Wrapping time differences
  assign since_change = tick_count - last_change_time;
  assign held_time    = tick_count - press_time;
  assign held_wide    = WIDE_W'(held_time);

  assign accept_level = (level != stable_button) &&
                        (since_change > TIME_BITS'(cfg.debounce_ticks));

  // Release reports duration and short/long class
  always_comb begin
    event_code = EVENT_NONE;
    held       = '0;
    if (accept_level && level == BUTTON_RELEASED) begin
      held       = held_wide[HELD_W-1:0];
      event_code = (held_time < TIME_BITS'(cfg.long_press_ticks)) ? EVENT_SHORT
                                                                  : EVENT_LONG;
    end
  end

  // State
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count       <= '0;
      last_change_time <= '0;
      press_time       <= '0;
      stable_button    <= BUTTON_RELEASED;
    end else if (en) begin
      tick_count <= tick_count + TIME_BITS'(1);
      if (accept_level) begin
        last_change_time <= tick_count;
        stable_button    <= level;
        if (level == BUTTON_PRESSED) begin
          press_time <= tick_count;
        end
      end
    end
  end

endmodule

// ===== design/rotary_dial_detent_and_button.sv =====
// Rotary dial detent counter with debounced push button.
// A word goes to the input register, then to the result register behind out_valid.
// Throughput: one word per cycle; input register feeds the decoders, result
// register holds the output; input stalls only while a word waits in the input
// register behind a stalled result word.
// Reset (rst, synchronous) clears valid flags and decoder state and loads register defaults.
// Depends on rdd_pkg, rdd_quad and rdd_button.
module rotary_dial_detent_and_button #(
  parameter int unsigned TIME_BITS = rdd_pkg::TIME_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration
  input  logic                             cfg_write,
  input  logic [rdd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rdd_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Sample input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             line_a,
  input  logic                             line_b,
  input  logic                             button_level,
  // Result output
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [1:0]                detent_step,
  output logic [1:0]                       press_event,
  output logic [rdd_pkg::HELD_W-1:0]       held_ticks
);
  import rdd_pkg::*;

  rdd_cfg_t cfg;

  logic       s1_valid;
  logic [1:0] s1_lines;
  logic       s1_level;
  logic       advance;

  logic signed [1:0]   detent;
  logic [1:0]          event_code;
  logic [HELD_W-1:0]   held;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulses_per_detent <= PPD_RESET;
      cfg.debounce_ticks    <= DEBOUNCE_RESET;
      cfg.long_press_ticks  <= LONG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PULSES_PER_DETENT: cfg.pulses_per_detent <= cfg_data[PPD_W-1:0];
        REG_DEBOUNCE_TICKS:    cfg.debounce_ticks    <= cfg_data[DEBOUNCE_W-1:0];
        REG_LONG_PRESS_TICKS:  cfg.long_press_ticks  <= cfg_data[LONG_W-1:0];
        default: ;
      endcase
    end
  end

  // Word moves from the input register to the result register
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_lines <= {line_a, line_b};
      s1_level <= button_level;
    end
  end

  rdd_quad u_quad (
    .clk               (clk),
    .rst               (rst),
    .en                (advance),
    .lines             (s1_lines),
    .pulses_per_detent (cfg.pulses_per_detent),
    .detent            (detent)
  );

  rdd_button #(
    .TIME_BITS (TIME_BITS)
  ) u_button (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .level      (s1_level),
    .cfg        (cfg),
    .event_code (event_code),
    .held       (held)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      detent_step <= detent;
      press_event <= event_code;
      held_ticks  <= held;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rotary_dial_detent_and_button: quadrature detent and button events.
// A cycle-level predictor is compared against every result word. Depends on rdd_pkg and the DUT.
module tb;
  import rdd_pkg::*;

  // Write index that maps to no register
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  // One full turn each way at the reset scale, then skipped states and a rest
  localparam logic [29:0] TURN_PATTERN = {2'b00, 2'b10, 2'b11, 2'b01, 2'b00,
                                          2'b01, 2'b11, 2'b10, 2'b00,
                                          2'b11, 2'b00, 2'b01, 2'b10, 2'b01, 2'b01};

  typedef struct packed {
    logic signed [1:0]   detent;
    logic [1:0]          press;
    logic [HELD_W-1:0]   held;
  } dial_result_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic line_a;
  logic line_b;
  logic button_level;
  logic out_valid;
  logic out_stall;
  logic signed [1:0] detent_step;
  logic [1:0] press_event;
  logic [HELD_W-1:0] held_ticks;

  // Predictor copy of the registers and the dial state
  logic [PPD_W-1:0]      scale_reg;
  logic [DEBOUNCE_W-1:0] debounce_reg;
  logic [LONG_W-1:0]     long_reg;
  logic [1:0]            last_lines;
  logic                  lines_seen;
  int                    step_count;
  logic [31:0]           tick_now;
  logic                  settled_button;
  logic [31:0]           last_accept_time;
  logic [31:0]           press_start;

  dial_result_t dial_expected[$];
  int fail_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off;
  int enc_pos;
  int enc_dir;

  rotary_dial_detent_and_button dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .line_a(line_a),
    .line_b(line_b),
    .button_level(button_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .detent_step(detent_step),
    .press_event(press_event),
    .held_ticks(held_ticks)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // Advance the dial by one sample and return the expected result word
  function automatic dial_result_t predict_tick(input logic a, input logic b, input logic btn);
    dial_result_t r;
    logic [3:0] code;
    int span;
    code = {last_lines, a, b};
    if (lines_seen) begin
      case (code)
        4'b0010, 4'b1011, 4'b1101, 4'b0100: step_count = step_count + 1;
        4'b0001, 4'b0111, 4'b1110, 4'b1000: step_count = step_count - 1;
        default: ;
      endcase
    end
    last_lines = {a, b};
    lines_seen = 1'b1;
    span = (scale_reg == 0) ? 1 : int'(scale_reg);
    r.detent = DETENT_NONE;
    r.press = EVENT_NONE;
    r.held = '0;
    // one detent per tick at most; any excess drains later
    if (step_count >= span) begin
      r.detent = DETENT_UP;
      step_count = step_count - span;
    end else if (step_count <= -span) begin
      r.detent = DETENT_DOWN;
      step_count = step_count + span;
    end
    // new level only after strictly more than the debounce window
    if (btn != settled_button && (tick_now - last_accept_time) > debounce_reg) begin
      last_accept_time = tick_now;
      settled_button = btn;
      if (btn == BUTTON_PRESSED) begin
        press_start = tick_now;
      end else begin
        r.held = tick_now - press_start;
        r.press = (r.held < long_reg) ? EVENT_SHORT : EVENT_LONG;
      end
    end
    tick_now = tick_now + 1;
    return r;
  endfunction

  // Predict on accepted input words, check accepted result words
  always @(posedge clk) begin : check_results
    dial_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall)
        dial_expected.push_back(predict_tick(line_a, line_b, button_level));
      if (out_valid && !out_stall) begin
        if (dial_expected.size() == 0) begin
          $error("result word with no expected word pending");
          fail_count++;
        end else begin
          want = dial_expected.pop_front();
          if (detent_step !== want.detent) begin
            $error("detent_step: expected %0d, got %0d", want.detent, detent_step);
            fail_count++;
          end
          if (press_event !== want.press) begin
            $error("press_event: expected %0d, got %0d", want.press, press_event);
            fail_count++;
          end
          if (held_ticks !== want.held) begin
            $error("held_ticks: expected %0d, got %0d", want.held, held_ticks);
            fail_count++;
          end
        end
      end
    end
  end

  // Receiver: random stalls, or a long counted hold-off when requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_stall = 1'b1;
        hold_off = hold_off - 1;
      end else begin
        out_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic logic [1:0] quad_lines(input int pos);
    case (pos)
      0: return 2'b00;
      1: return 2'b10;
      2: return 2'b11;
      default: return 2'b01;
    endcase
  endfunction

  // Mostly clean quadrature motion with reversals, pauses, skips and junk
  function automatic logic [1:0] next_quadrature();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) enc_dir = -enc_dir;
    if (pick < 75) enc_pos = (enc_pos + enc_dir + 4) % 4;
    else if (pick >= 93) enc_pos = $urandom_range(3);
    else if (pick >= 85) enc_pos = (enc_pos + 2) % 4;
    return quad_lines(enc_pos);
  endfunction

  // Send one input word; called and returns at a falling edge
  task automatic send_sample(input logic a, input logic b, input logic btn);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    line_a = a;
    line_b = b;
    button_level = btn;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drain everything in flight before touching registers
  task automatic settle();
    in_valid = 1'b0;
    while (dial_expected.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      REG_PULSES_PER_DETENT: scale_reg = data[PPD_W-1:0];
      REG_DEBOUNCE_TICKS:    debounce_reg = data[DEBOUNCE_W-1:0];
      REG_LONG_PRESS_TICKS:  long_reg = data[LONG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Hold the button at one level for a number of words while the dial moves
  task automatic hold_button(input logic level, input int words);
    logic [1:0] lines;
    repeat (words) begin
      lines = next_quadrature();
      send_sample(lines[1], lines[0], level);
    end
  endtask

  // Reset scale: priming word, one detent each way, skipped states ignored;
  // early button flips fall inside the reset debounce window
  task automatic test_rotation_defaults();
    set_idling(0, 0);
    for (int i = 14; i >= 0; i--)
      send_sample(TURN_PATTERN[2*i+1], TURN_PATTERN[2*i], i[0]);
  endtask

  // Scale of zero acts as one; zero long threshold makes every release long
  task automatic test_zero_scale_and_threshold();
    settle();
    write_reg(REG_PULSES_PER_DETENT, 16'hFFE0);
    write_reg(REG_DEBOUNCE_TICKS, 16'h0000);
    write_reg(REG_LONG_PRESS_TICKS, 16'h0000);
    write_reg(REG_UNUSED, 16'hA5A5);
    send_sample(1'b0, 1'b0, BUTTON_PRESSED);
    send_sample(1'b1, 1'b0, BUTTON_RELEASED);
    send_sample(1'b1, 1'b0, BUTTON_RELEASED);
    settle();
    // short and long releases around a threshold of two
    write_reg(REG_LONG_PRESS_TICKS, 16'd2);
    send_sample(1'b1, 1'b1, BUTTON_PRESSED);
    send_sample(1'b0, 1'b1, BUTTON_RELEASED);
    send_sample(1'b0, 1'b0, BUTTON_PRESSED);
    send_sample(1'b0, 1'b0, BUTTON_PRESSED);
    send_sample(1'b0, 1'b0, BUTTON_RELEASED);
  endtask

  // A level is taken only once the window has strictly passed
  task automatic test_debounce_window();
    settle();
    write_reg(REG_DEBOUNCE_TICKS, 16'd3);
    repeat (4) send_sample(1'b0, 1'b0, BUTTON_PRESSED);
  endtask

  // Residual left above a lowered scale drains one detent per tick
  task automatic test_residual_drain();
    logic [1:0] lines;
    settle();
    write_reg(REG_PULSES_PER_DETENT, 16'd8);
    for (int i = 1; i <= 7; i++) begin
      lines = quad_lines(i % 4);
      send_sample(lines[1], lines[0], BUTTON_RELEASED);
    end
    settle();
    write_reg(REG_PULSES_PER_DETENT, 16'd2);
    repeat (4) send_sample(1'b0, 1'b1, BUTTON_RELEASED);
  endtask

  // Random dial motion with press/release runs and the odd bounce
  task automatic test_random_traffic(input int words, input int hold_lo, input int hold_hi);
    int hold_left;
    logic level;
    logic [1:0] lines;
    logic btn;
    hold_left = 0;
    level = BUTTON_RELEASED;
    repeat (words) begin
      lines = next_quadrature();
      if (hold_left == 0) begin
        level = ~level;
        hold_left = $urandom_range(hold_hi, hold_lo);
      end
      hold_left--;
      btn = ($urandom_range(99) < 4) ? ~level : level;
      send_sample(lines[1], lines[0], btn);
    end
  endtask

  // Receiver holds off for a long stretch while words keep coming
  task automatic test_output_backpressure();
    logic [1:0] lines;
    logic btn;
    settle();
    set_idling(0, 0);
    hold_off = 250;
    repeat (40) begin
      lines = next_quadrature();
      btn = 1'($urandom_range(1));
      send_sample(lines[1], lines[0], btn);
    end
  endtask

  // Held time exactly at the long threshold, then one tick short of it
  task automatic test_long_press_extremes();
    settle();
    set_idling(0, 0);
    write_reg(REG_PULSES_PER_DETENT, 16'd1);
    write_reg(REG_DEBOUNCE_TICKS, 16'd30);
    write_reg(REG_LONG_PRESS_TICKS, 16'd64);
    hold_button(BUTTON_RELEASED, 80);
    hold_button(BUTTON_PRESSED, 64);
    hold_button(BUTTON_RELEASED, 40);
    hold_button(BUTTON_PRESSED, 63);
    hold_button(BUTTON_RELEASED, 40);
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_PULSES_PER_DETENT;
    cfg_data = '0;
    in_valid = 1'b0;
    line_a = 1'b0;
    line_b = 1'b0;
    button_level = BUTTON_RELEASED;
    fail_count = 0;
    hold_off = 0;
    enc_pos = 0;
    enc_dir = 1;
    set_idling(0, 0);
    scale_reg = PPD_RESET;
    debounce_reg = DEBOUNCE_RESET;
    long_reg = LONG_RESET;
    last_lines = 2'b00;
    lines_seen = 1'b0;
    step_count = 0;
    tick_now = '0;
    settled_button = BUTTON_RELEASED;
    last_accept_time = '0;
    press_start = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_rotation_defaults();
    test_zero_scale_and_threshold();
    test_debounce_window();
    test_residual_drain();

    settle();
    write_reg(REG_PULSES_PER_DETENT, 16'd2);
    write_reg(REG_DEBOUNCE_TICKS, 16'd3);
    write_reg(REG_LONG_PRESS_TICKS, 16'd12);
    set_idling(18, 85);
    test_random_traffic(100, 1, 30);

    settle();
    write_reg(REG_PULSES_PER_DETENT, 16'd16);
    write_reg(REG_DEBOUNCE_TICKS, 16'd0);
    write_reg(REG_LONG_PRESS_TICKS, 16'd1);
    set_idling(85, 18);
    test_random_traffic(100, 1, 20);

    settle();
    write_reg(REG_PULSES_PER_DETENT, 16'd5);
    write_reg(REG_DEBOUNCE_TICKS, 16'd20);
    write_reg(REG_LONG_PRESS_TICKS, 16'd300);
    set_idling(0, 0);
    test_random_traffic(100, 10, 600);

    test_output_backpressure();
    test_long_press_extremes();

    settle();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && dial_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
